### src/stable_argsort_assert.svh
// Assertion macros for the stable argsort block.
`ifndef STABLE_ARGSORT_ASSERT_SVH
`define STABLE_ARGSORT_ASSERT_SVH
`ifndef SYNTHESIS
`define SA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/sa_pkg.sv
//------------------------------------------------------------------------------
// sa_pkg: shared types and constants
// Defaults and the state encoding of the stable argsort block.
//------------------------------------------------------------------------------
`default_nettype none
package sa_pkg;
  localparam int MaxItemsDefault = 64;
  localparam int KeyWidth = 32;
  localparam int PosWidth = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Total order over IEEE bit patterns as an unsigned value.
  function automatic logic [KeyWidth-1:0] order_value(input logic [KeyWidth-1:0] bits);
    order_value = bits[KeyWidth-1] ? ~bits : (bits ^ {1'b1, {(KeyWidth-1){1'b0}}});
  endfunction
endpackage
`default_nettype wire

### src/stable_argsort.sv
//------------------------------------------------------------------------------
// stable_argsort: stable argsort of single-precision keys
// A chain of insertion cells sorts keys as they arrive and drains positions.
//------------------------------------------------------------------------------
// Channel  Dir  Fields (tdata low bit up)                   Handshake
// s_axis   in   tdata: key_bits[31:0]; tlast: final_key     tvalid/tready
// m_axis   out  tdata: position[5:0], zero pad; tlast: final_rank;
//               tuser: overflowed                            tvalid/tready
// One key is taken per cycle while the set loads; each key is placed in the
// chain as it is accepted, every cell comparing against it in parallel.
// After the final key the chain shifts toward the head, one beat per cycle
// while m_axis_tready is high, so a run of N stored keys drains as N beats.
// No key is accepted during the drain. Reset is synchronous and empties the
// chain. Stalls on the output hold the chain and the output beat.
//------------------------------------------------------------------------------
`default_nettype none
module stable_argsort #(
  parameter int MAX_ITEMS = sa_pkg::MaxItemsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // key_bits[31:0]
  input  wire logic        s_axis_tlast,  // final_key
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // position[5:0], zeros above
  output logic             m_axis_tlast,  // final_rank
  output logic             m_axis_tuser   // overflowed
);
  import sa_pkg::*;
  `include "stable_argsort_assert.svh"

  localparam int CntW = $clog2(MAX_ITEMS + 1);

  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [PosWidth-1:0] arrivals;
  logic ovf;

  logic [MAX_ITEMS-1:0] c_full, c_gt;
  logic [KeyWidth-1:0]  c_ord [MAX_ITEMS];
  logic [PosWidth-1:0]  c_pos [MAX_ITEMS];

  logic in_acc, out_acc, ins, drain, store_full, last_out;
  logic [KeyWidth-1:0] new_ord;

  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign store_full = (count == CntW'(MAX_ITEMS));
  assign ins        = in_acc && !store_full;
  assign drain      = out_acc;
  assign new_ord    = order_value(s_axis_tdata);
  assign last_out   = (count == CntW'(1));

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic pg, pf, nf;
      logic [KeyWidth-1:0] po, no;
      logic [PosWidth-1:0] pp, np;
      if (i == 0) begin : g_head
        assign pg = 1'b0; assign pf = 1'b1; assign po = '0; assign pp = '0;
      end else begin : g_mid
        assign pg = c_gt[i-1]; assign pf = c_full[i-1];
        assign po = c_ord[i-1]; assign pp = c_pos[i-1];
      end
      if (i == MAX_ITEMS - 1) begin : g_tail
        assign nf = 1'b0; assign no = '0; assign np = '0;
      end else begin : g_body
        assign nf = c_full[i+1]; assign no = c_ord[i+1]; assign np = c_pos[i+1];
      end
      sa_cell u_cell (
        .clk(clk), .rst(rst), .clear(1'b0), .ins(ins), .drain(drain),
        .new_ord(new_ord), .new_pos(arrivals),
        .prev_gt(pg), .prev_full(pf), .prev_ord(po), .prev_pos(pp),
        .next_full(nf), .next_ord(no), .next_pos(np),
        .full(c_full[i]), .gt(c_gt[i]), .ord(c_ord[i]), .pos(c_pos[i])
      );
    end
  endgenerate

  // Next-state logic: drain starts after the final key if anything is stored.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && s_axis_tlast && (ins || count != '0)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_acc && last_out) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Output logic.
  always_comb begin
    s_axis_tready = (state == ST_LOAD);
    m_axis_tvalid = (state == ST_DRAIN);
    m_axis_tdata  = {{(8-PosWidth){1'b0}}, c_pos[0]};
    m_axis_tlast  = last_out;
    m_axis_tuser  = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      arrivals <= '0;
      ovf      <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (s_axis_tlast && !ins && count == '0) begin
          // Final key dropped into an empty store: nothing to emit.
          arrivals <= '0;
          ovf      <= 1'b0;
        end else begin
          arrivals <= arrivals + PosWidth'(1);
          if (!ins) ovf <= 1'b1;
        end
        if (ins) count <= count + CntW'(1);
      end else if (out_acc) begin
        count <= count - CntW'(1);
        if (last_out) begin
          arrivals <= '0;
          ovf      <= 1'b0;
        end
      end
    end
  end

  `SA_ASSERT_IMPL(a_no_in_drain, clk, rst, state == ST_DRAIN, !s_axis_tready)
  `SA_ASSERT_IMPL(a_valid_has_data, clk, rst, m_axis_tvalid, count != '0 && c_full[0])
  `SA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CntW'(MAX_ITEMS))
  `SA_ASSERT_NEXT(a_last_ends, clk, rst, out_acc && m_axis_tlast, state == ST_LOAD)
endmodule
`default_nettype wire

### src/sa_cell.sv
//------------------------------------------------------------------------------
// sa_cell: one slot of the insertion chain
// Holds one key with its position; in load mode it keeps, takes the new key,
// or takes its left neighbor's entry; in drain mode it shifts toward the head.
//------------------------------------------------------------------------------
`default_nettype none
module sa_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire logic                        ins,
  input  wire logic                        drain,
  input  wire logic [sa_pkg::KeyWidth-1:0] new_ord,
  input  wire logic [sa_pkg::PosWidth-1:0] new_pos,
  input  wire logic                        prev_gt,
  input  wire logic                        prev_full,
  input  wire logic [sa_pkg::KeyWidth-1:0] prev_ord,
  input  wire logic [sa_pkg::PosWidth-1:0] prev_pos,
  input  wire logic                        next_full,
  input  wire logic [sa_pkg::KeyWidth-1:0] next_ord,
  input  wire logic [sa_pkg::PosWidth-1:0] next_pos,
  output logic                             full,
  output logic                             gt,
  output logic [sa_pkg::KeyWidth-1:0]      ord,
  output logic [sa_pkg::PosWidth-1:0]      pos
);
  import sa_pkg::*;
  // A full cell whose key is strictly above the new one must move right.
  assign gt = full && (ord > new_ord);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      full <= 1'b0;
    end else if (drain) begin
      full <= next_full;
    end else if (ins && (gt || !full)) begin
      // An empty cell fills only when its left neighbor holds an entry.
      full <= prev_full;
    end
    if (drain) begin
      ord <= next_ord;
      pos <= next_pos;
    end else if (ins && (gt || !full)) begin
      if (prev_gt) begin
        ord <= prev_ord;
        pos <= prev_pos;
      end else if (gt || (!full && prev_full)) begin
        ord <= new_ord;
        pos <= new_pos;
      end
    end
  end
endmodule
`default_nettype wire

### test/tb.sv
//------------------------------------------------------------------------------
// tb: self-checking bench for stable_argsort
// Streams sets of float keys into the sorter, predicts the drained positions
// with a stable insertion model, and checks every output beat field by field.
//------------------------------------------------------------------------------
`default_nettype none
module tb;
  localparam int MaxKeys = sa_pkg::MaxItemsDefault;
  localparam int StallLimit = 5000;

  typedef struct packed {
    logic [31:0] key;
    logic        last;
  } key_beat_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       last;
    logic       ovf;
  } rank_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  always #5 clk = ~clk;

  stable_argsort u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  // Predictor state: sorted keys with their arrival positions.
  logic [31:0] sorted_keys[MaxKeys];
  logic [5:0]  sorted_pos[MaxKeys];
  int          stored_count = 0;
  int          arrival_count = 0;
  logic        dropped = 1'b0;
  rank_beat_t  pending_ranks[$];
  int          errors = 0;
  int          keys_sent = 0;
  int          ranks_seen = 0;
  int          sets_done = 0;
  int          idle_cycles = 0;

  // Map a float pattern to an unsigned value that sorts in IEEE total order.
  function automatic logic [31:0] total_order(logic [31:0] b);
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

  // Insert one key; on the final key queue the positions in sorted order.
  task automatic sort_key(key_beat_t kb);
    int slot;
    rank_beat_t beat;
    if (stored_count < MaxKeys) begin
      slot = stored_count;
      while (slot > 0 && total_order(sorted_keys[slot-1]) > total_order(kb.key)) begin
        sorted_keys[slot] = sorted_keys[slot-1];
        sorted_pos[slot] = sorted_pos[slot-1];
        slot--;
      end
      sorted_keys[slot] = kb.key;
      sorted_pos[slot] = arrival_count[5:0];
      stored_count++;
    end else begin
      dropped = 1'b1;
    end
    arrival_count++;
    if (kb.last) begin
      for (int k = 0; k < stored_count; k++) begin
        beat.pos = sorted_pos[k];
        beat.last = (k == stored_count - 1);
        beat.ovf = dropped;
        pending_ranks.insert(pending_ranks.size(), beat);
      end
      stored_count = 0;
      arrival_count = 0;
      dropped = 1'b0;
      sets_done++;
    end
  endtask

  // Sample both channels at the rising edge; the predictor runs on accepts.
  always @(posedge clk) begin
    rank_beat_t got, want;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        sort_key('{s_axis_tdata, s_axis_tlast});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        ranks_seen++;
        got = '{m_axis_tdata[5:0], m_axis_tlast, m_axis_tuser};
        if (m_axis_tdata[7:6] != 2'b00) begin
          errors++;
          $display("%0t: pad bits: expected 0 actual %0d", $time, m_axis_tdata[7:6]);
        end
        if (pending_ranks.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat pos %0d last %0b ovf %0b",
                   $time, got.pos, got.last, got.ovf);
        end else begin
          want = pending_ranks.pop_front();
          if (got.pos !== want.pos) begin
            errors++;
            $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t: final_rank expected %0b actual %0b", $time, want.last, got.last);
          end
          if (got.ovf !== want.ovf) begin
            errors++;
            $display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, got.ovf);
          end
        end
      end
    end
  end

  // Watchdog: too long with nothing accepted on either side ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= StallLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("stable_argsort regression: fail");
      $finish;
    end
  end

  // Receiver stall pattern: alternating phases of full speed and random stalls.
  int stall_phase = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 200;
      if (stall_phase < 60) m_axis_tready <= 1'b1;
      else if (stall_phase < 140) m_axis_tready <= ($urandom_range(3) != 0);
      else m_axis_tready <= ($urandom_range(3) == 0);
    end
  end

  // Sender burst state.
  int burst_left = 0;

  // Drive one key at the falling edge and hold it until accepted. Between
  // bursts, a random gap is inserted with valid low.
  task automatic send_key(logic [31:0] key, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= key;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    keys_sent++;
  endtask

  task automatic idle_sender;
    s_axis_tvalid <= 1'b0;
    s_axis_tlast <= 1'b0;
  endtask

  // Random key: mostly any pattern, otherwise a small value pool to force ties
  // or one of the signed zeros, infinities and NaNs mixed in.
  function automatic logic [31:0] random_key();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 31'(31'h3f800000 + $urandom_range(3))};
      1: begin
        case ($urandom_range(5))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7f80_0000;
          3: return 32'hff80_0000;
          4: return 32'h7fc0_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Directed table of keys and final flags. The expected drain order is held
  // apart, in zero_set_order, for the short, hand-readable signed-zero set.
  typedef struct {
    logic [31:0] key;
    logic        last;
  } directed_row_t;

  directed_row_t directed[20] = '{
    // Single-key set: position 0, final.
    '{32'h3f80_0000, 1'b1},
    // Signed zeros and infinities: -inf, -0, +0, +inf drain as 2,1,3,0.
    '{32'h7f80_0000, 1'b0}, '{32'h8000_0000, 1'b0},
    '{32'hff80_0000, 1'b0}, '{32'h0000_0000, 1'b1},
    // NaNs of both signs and the extreme patterns.
    '{32'hffff_ffff, 1'b0}, '{32'h7fff_ffff, 1'b0},
    '{32'h8000_0001, 1'b0}, '{32'h0000_0001, 1'b0},
    '{32'h7f7f_ffff, 1'b0}, '{32'hff7f_ffff, 1'b1},
    // Ties must keep arrival order.
    '{32'h4000_0000, 1'b0}, '{32'h3f80_0000, 1'b0},
    '{32'h4000_0000, 1'b0}, '{32'h3f80_0000, 1'b0},
    '{32'h4000_0000, 1'b1},
    // Descending run: worst case for insertion.
    '{32'h4080_0000, 1'b0}, '{32'h4040_0000, 1'b0},
    '{32'h4000_0000, 1'b0}, '{32'h3f80_0000, 1'b1}
  };

  // Expected drain for the signed-zero set, read directly off the ordering.
  logic [5:0] zero_set_order[4] = '{6'd2, 6'd1, 6'd3, 6'd0};

  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The signed-zero set is typed in by hand; compare predictor against it.
    for (int i = 0; i < $size(directed); i++) begin
      send_key(directed[i].key, directed[i].last);
      if (i == 4) begin
        for (int k = 0; k < 4; k++)
          if (pending_ranks.size() >= 4 - k + 0 &&
              pending_ranks[pending_ranks.size() - 4 + k].pos !== zero_set_order[k]) begin
            errors++;
            $display("%0t: zero ordering rank %0d expected %0d actual %0d", $time, k,
                     zero_set_order[k], pending_ranks[pending_ranks.size() - 4 + k].pos);
          end
      end
    end

    // Overflow set: capacity plus a few keys, final one dropped too.
    for (int i = 0; i < MaxKeys + 3; i++)
      send_key(random_key(), i == MaxKeys + 2);

    // Random sets, mostly short, a few at or just past capacity.
    while (keys_sent < 175) begin
      case ($urandom_range(9))
        0: n = (keys_sent + MaxKeys + 2 < 180) ? MaxKeys + int'($urandom_range(0, 2)) : 1;
        1: n = 1;
        default: n = int'($urandom_range(2, 12));
      endcase
      for (int i = 0; i < n; i++) send_key(random_key(), i == n - 1);
    end
    idle_sender();

    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (MaxKeys + 20) @(posedge clk);

    $display("Covered %0d keys in %0d sets, %0d ranked beats checked,", keys_sent,
             sets_done, ranks_seen);
    $display("including ties, signed zeros, NaNs, infinities and overflowing sets.");
    if (errors == 0) begin
      $display("stable_argsort regression: pass");
    end else begin
      $display("stable_argsort regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+src
src/sa_pkg.sv
src/sa_cell.sv
src/stable_argsort.sv
test/tb.sv
